>>> sv/text_escape_cursor_formatter_assert.svh
// Assertion macros shared by the checker of the text formatter.
`ifndef TEXT_ESCAPE_CURSOR_FORMATTER_ASSERT_SVH
`define TEXT_ESCAPE_CURSOR_FORMATTER_ASSERT_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define TECF_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous active-low reset.
`define TECF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tecf_pkg.sv
`default_nettype none
package tecf_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SIX   = 8'h36;

	localparam logic [3:0] COLOUR_WHITE = 4'd0;

	// What one character does to the formatter.
	typedef enum logic [2:0] {
		ACT_PRINT,
		ACT_OPEN,
		ACT_ROW,
		ACT_COLOUR,
		ACT_IGNORE
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [2:0] row;
		logic [3:0] colour;
	} dec_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} colour_hit_t;

	function automatic colour_hit_t colour_of_letter(input logic [7:0] ch);
		colour_hit_t r;
		r.hit = 1'b1;
		case (ch)
			8'h77:   r.idx = 4'd0;   // w
			8'h72:   r.idx = 4'd1;   // r
			8'h67:   r.idx = 4'd2;   // g
			8'h62:   r.idx = 4'd3;   // b
			8'h79:   r.idx = 4'd4;   // y
			8'h63:   r.idx = 4'd5;   // c
			8'h6D:   r.idx = 4'd6;   // m
			8'h6F:   r.idx = 4'd7;   // o
			8'h6C:   r.idx = 4'd8;   // l
			8'h74:   r.idx = 4'd9;   // t
			8'h73:   r.idx = 4'd10;  // s
			8'h76:   r.idx = 4'd11;  // v
			8'h70:   r.idx = 4'd12;  // p
			8'h4B:   r.idx = 4'd13;  // K
			8'h6B:   r.idx = 4'd14;  // k
			default: begin
				r.hit = 1'b0;
				r.idx = COLOUR_WHITE;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/tecf_decode.sv
`default_nettype none
module tecf_decode (
	input  wire logic [7:0]   char_code,
	input  wire logic         pending,
	output tecf_pkg::dec_t    dec
);
	import tecf_pkg::*;

	colour_hit_t col;
	logic        is_digit;

	assign col      = colour_of_letter(char_code);
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_SIX);

	always_comb begin
		dec.row    = 3'(char_code - CHAR_ZERO);
		dec.colour = col.idx;
		if (char_code == CHAR_NUL) begin
			dec.action = ACT_IGNORE;
		end else if (!pending) begin
			dec.action = (char_code == CHAR_SLASH) ? ACT_OPEN : ACT_PRINT;
		end else if (char_code == CHAR_SLASH) begin
			dec.action = ACT_PRINT;
		end else if (is_digit) begin
			dec.action = ACT_ROW;
		end else if (col.hit) begin
			dec.action = ACT_COLOUR;
		end else begin
			dec.action = ACT_IGNORE;
		end
	end

endmodule
`default_nettype wire

>>> sv/text_escape_cursor_formatter.sv
// Text escape and cursor formatter. Feed one text byte per request on the
// text channel, with start_of_text high on the first byte of a string; that
// byte resets the cursor to 0,0, the colour to white and drops any pending
// escape. Every printable byte returns one placement on the glyph channel
// (code, colour index, pixel x/y, on_screen); escapes, end-of-text zeros and
// unknown escapes return nothing. Throughput is one request per cycle while
// the glyph channel is not stalled: a byte is held in the input register while
// the decode and cursor update run, and its placement is registered in the
// result register. The only feedback path is the small cursor/colour/escape
// register set, updated in the same cycle as the result register is loaded.
// Downstream stalls back-pressure the input through text_ready.
`default_nettype none
module text_escape_cursor_formatter #(
	parameter int GLYPH_WIDTH   = 5,
	parameter int GLYPH_HEIGHT  = 8,
	parameter int SCREEN_WIDTH  = 96,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       start_of_text,
	output logic            glyph_valid,
	input  wire logic       glyph_ready,
	output logic [7:0]      glyph_code,
	output logic [3:0]      colour_index,
	output logic [7:0]      pos_x,
	output logic [5:0]      pos_y,
	output logic            on_screen
);
	import tecf_pkg::*;

	// Horizontal step per glyph includes one pixel of spacing.
	localparam logic [8:0] X_STEP    = 9'(GLYPH_WIDTH + 1);
	localparam logic [8:0] X_EXTENT  = 9'(GLYPH_WIDTH);
	localparam logic [8:0] X_LIMIT   = 9'(SCREEN_WIDTH);
	localparam logic [6:0] Y_EXTENT  = 7'(GLYPH_HEIGHT);
	localparam logic [6:0] Y_LIMIT   = 7'(SCREEN_HEIGHT);
	localparam logic [3:0] ROW_PITCH = 4'(GLYPH_HEIGHT + 1);

	// Input register
	logic       valid_s1;
	logic [7:0] char_code_s1;
	logic       start_s1;

	// Result register
	logic       valid_s2;
	logic [7:0] glyph_code_s2;
	logic [3:0] colour_s2;
	logic [7:0] pos_x_s2;
	logic [5:0] pos_y_s2;
	logic       on_screen_s2;

	// Formatter state
	logic       escape_pending_q;
	logic [7:0] cursor_x_q;
	logic [5:0] cursor_y_q;
	logic [3:0] colour_q;

	logic       advance;
	logic       pend_eff;
	logic [7:0] x_eff;
	logic [5:0] y_eff;
	logic [3:0] col_eff;
	dec_t       dec;
	logic [8:0] x_next_wide;
	logic [7:0] x_next;
	logic [7:0] row_y_wide;
	logic [5:0] row_y;
	logic       fits;
	logic       emit;

	// Move the held byte on whenever the result slot is free or being drained.
	assign advance    = valid_s1 && (!valid_s2 || glyph_ready);
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			char_code_s1 <= char_code;
			start_s1     <= start_of_text;
		end
	end

	// A new string overrides the stored state before the byte is looked at.
	assign pend_eff = start_s1 ? 1'b0         : escape_pending_q;
	assign x_eff    = start_s1 ? 8'd0         : cursor_x_q;
	assign y_eff    = start_s1 ? 6'd0         : cursor_y_q;
	assign col_eff  = start_s1 ? COLOUR_WHITE : colour_q;

	tecf_decode u_decode (
		.char_code (char_code_s1),
		.pending   (pend_eff),
		.dec       (dec)
	);

	// Saturate the cursor at the right edge rather than wrap.
	assign x_next_wide = {1'b0, x_eff} + X_STEP;
	assign x_next      = x_next_wide[8] ? 8'hFF : x_next_wide[7:0];

	assign row_y_wide = {4'd0, ROW_PITCH} * {5'd0, dec.row};
	assign row_y      = (row_y_wide > 8'd63) ? 6'd63 : row_y_wide[5:0];

	assign fits = (({1'b0, x_eff} + X_EXTENT) <= X_LIMIT) &&
	              (({1'b0, y_eff} + Y_EXTENT) <= Y_LIMIT);

	assign emit = (dec.action == ACT_PRINT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
			cursor_x_q       <= 8'd0;
			cursor_y_q       <= 6'd0;
			colour_q         <= COLOUR_WHITE;
		end else if (advance) begin
			escape_pending_q <= (dec.action == ACT_OPEN);
			cursor_y_q       <= y_eff;
			colour_q         <= col_eff;
			cursor_x_q       <= x_eff;
			case (dec.action)
				ACT_PRINT: begin
					cursor_x_q <= x_next;
				end
				ACT_ROW: begin
					cursor_x_q <= 8'd0;
					cursor_y_q <= row_y;
				end
				ACT_COLOUR: begin
					colour_q <= dec.colour;
				end
				default: begin
					// hold the cursor and colour
				end
			endcase
		end
	end

	// Result valid: set by a printing byte, drop once taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (glyph_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			glyph_code_s2 <= char_code_s1;
			colour_s2     <= col_eff;
			pos_x_s2      <= x_eff;
			pos_y_s2      <= y_eff;
			on_screen_s2  <= fits;
		end
	end

	assign glyph_valid  = valid_s2;
	assign glyph_code   = glyph_code_s2;
	assign colour_index = colour_s2;
	assign pos_x        = pos_x_s2;
	assign pos_y        = pos_y_s2;
	assign on_screen    = on_screen_s2;

endmodule
`default_nettype wire

>>> sv/tecf_checker.sv
`default_nettype none
module tecf_checker #(
	parameter int GLYPH_WIDTH   = 5,
	parameter int GLYPH_HEIGHT  = 8,
	parameter int SCREEN_WIDTH  = 96,
	parameter int SCREEN_HEIGHT = 64
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       text_valid,
	input wire logic       text_ready,
	input wire logic [7:0] char_code,
	input wire logic       start_of_text,
	input wire logic       glyph_valid,
	input wire logic       glyph_ready,
	input wire logic [7:0] glyph_code,
	input wire logic [3:0] colour_index,
	input wire logic [7:0] pos_x,
	input wire logic [5:0] pos_y,
	input wire logic       on_screen
);
	`include "text_escape_cursor_formatter_assert.svh"

	localparam logic [8:0] X_EXTENT = 9'(GLYPH_WIDTH);
	localparam logic [8:0] X_LIMIT  = 9'(SCREEN_WIDTH);
	localparam logic [6:0] Y_EXTENT = 7'(GLYPH_HEIGHT);
	localparam logic [6:0] Y_LIMIT  = 7'(SCREEN_HEIGHT);

	logic        fits;
	logic        text_stall;
	logic        glyph_stall;
	logic [9:0]  text_bus;
	logic [22:0] glyph_bus;

	assign fits = (({1'b0, pos_x} + X_EXTENT) <= X_LIMIT) &&
	              (({1'b0, pos_y} + Y_EXTENT) <= Y_LIMIT);

	// A waiting request or placement keeps valid high, so it is part of the bundle.
	assign text_stall  = text_valid && !text_ready;
	assign glyph_stall = glyph_valid && !glyph_ready;
	assign text_bus    = {text_valid, char_code, start_of_text};
	assign glyph_bus   = {glyph_valid, glyph_code, pos_x, pos_y};

	`TECF_ASSERT_NEXT(a_text_hold, clk, arst_n, text_stall, $stable(text_bus), "request moved")
	`TECF_ASSERT_NEXT(a_glyph_hold, clk, arst_n, glyph_stall, $stable(glyph_bus), "placement moved")
	`TECF_ASSERT_NOW(a_colour_range, clk, arst_n, glyph_valid, colour_index < 4'd15, "bad colour")
	`TECF_ASSERT_NOW(a_on_screen, clk, arst_n, glyph_valid, on_screen == fits, "on_screen wrong")

endmodule

bind text_escape_cursor_formatter tecf_checker #(
	.GLYPH_WIDTH   (GLYPH_WIDTH),
	.GLYPH_HEIGHT  (GLYPH_HEIGHT),
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tecf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.text_valid    (text_valid),
	.text_ready    (text_ready),
	.char_code     (char_code),
	.start_of_text (start_of_text),
	.glyph_valid   (glyph_valid),
	.glyph_ready   (glyph_ready),
	.glyph_code    (glyph_code),
	.colour_index  (colour_index),
	.pos_x         (pos_x),
	.pos_y         (pos_y),
	.on_screen     (on_screen)
);
`default_nettype wire

>>> bench/tb_text_escape_cursor_formatter.sv
`default_nettype none
module tb_text_escape_cursor_formatter;
	import tecf_pkg::*;

	// Geometry of the block under test; passed to the instance so both agree.
	localparam int GLYPH_WIDTH   = 5;
	localparam int GLYPH_HEIGHT  = 8;
	localparam int SCREEN_WIDTH  = 96;
	localparam int SCREEN_HEIGHT = 64;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 4;
	localparam int MAX_GAP      = 13;
	// Allow a generous tail after the pipeline drains before the final verdict.
	localparam int DRAIN_CYCLES = 16;
	// Cycles with no handshake on either channel before the run is abandoned.
	localparam int STALL_LIMIT  = 400;
	localparam int RANDOM_ITEMS = 1400;

	// Colour indices as the escape letters select them.
	typedef enum logic [3:0] {
		CLR_WHITE, CLR_RED, CLR_GREEN, CLR_BLUE, CLR_YELLOW,
		CLR_CYAN, CLR_MAGENTA, CLR_ORANGE, CLR_LIME, CLR_MINT,
		CLR_SEA, CLR_VIOLET, CLR_ROSE, CLR_GRAY, CLR_BLACK
	} colour_t;

	localparam int NUM_COLOURS = 15;

	// One placement as the glyph channel presents it.
	typedef struct packed {
		logic [7:0] code;
		logic [3:0] colour;
		logic [7:0] x;
		logic [5:0] y;
		logic       fits;
	} placement_t;

	logic       clk;
	logic       arst_n;
	logic       text_valid;
	logic       text_ready;
	logic [7:0] char_code;
	logic       start_of_text;
	logic       glyph_valid;
	logic       glyph_ready;
	logic [7:0] glyph_code;
	logic [3:0] colour_index;
	logic [7:0] pos_x;
	logic [5:0] pos_y;
	logic       on_screen;

	// Shadow of the formatter state, advanced once per accepted request.
	logic       shadow_escape;
	logic [7:0] shadow_x;
	logic [5:0] shadow_y;
	logic [3:0] shadow_colour;

	placement_t expected_glyphs[$];

	int  mismatches;
	int  bytes_sent;
	int  strings_sent;
	int  glyphs_checked;
	int  escapes_sent;
	int  idle_cycles;
	bit  no_idle;

	text_escape_cursor_formatter #(
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.char_code    (char_code),
		.start_of_text(start_of_text),
		.glyph_valid  (glyph_valid),
		.glyph_ready  (glyph_ready),
		.glyph_code   (glyph_code),
		.colour_index (colour_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.on_screen    (on_screen)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hold every input at a known value from time zero.
	initial begin
		arst_n        = 1'b0;
		text_valid    = 1'b0;
		char_code     = CHAR_NUL;
		start_of_text = 1'b0;
		glyph_ready   = 1'b0;
		no_idle       = 1'b0;
		mismatches    = 0;
		bytes_sent    = 0;
		strings_sent  = 0;
		glyphs_checked = 0;
		escapes_sent  = 0;
		idle_cycles   = 0;
		shadow_escape = 1'b0;
		shadow_x      = '0;
		shadow_y      = '0;
		shadow_colour = COLOUR_WHITE;
	end

	// Escape letter for a colour index: the one table both the predictor
	// and the stimulus work from.
	function automatic logic [7:0] letter_of(input colour_t c);
		case (c)
			CLR_WHITE:   return "w";
			CLR_RED:     return "r";
			CLR_GREEN:   return "g";
			CLR_BLUE:    return "b";
			CLR_YELLOW:  return "y";
			CLR_CYAN:    return "c";
			CLR_MAGENTA: return "m";
			CLR_ORANGE:  return "o";
			CLR_LIME:    return "l";
			CLR_MINT:    return "t";
			CLR_SEA:     return "s";
			CLR_VIOLET:  return "v";
			CLR_ROSE:    return "p";
			CLR_GRAY:    return "K";
			default:     return "k";
		endcase
	endfunction

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Queue the placement for a printed byte and move the shadow cursor on,
	// saturating at the right edge rather than wrapping.
	task automatic place_glyph(input logic [7:0] c);
		placement_t p;
		int         nx;
		p.code   = c;
		p.colour = shadow_colour;
		p.x      = shadow_x;
		p.y      = shadow_y;
		p.fits   = (int'(shadow_x) + GLYPH_WIDTH <= SCREEN_WIDTH) &&
		           (int'(shadow_y) + GLYPH_HEIGHT <= SCREEN_HEIGHT);
		expected_glyphs.push_back(p);
		nx = int'(shadow_x) + GLYPH_WIDTH + 1;
		shadow_x = (nx > 255) ? 8'd255 : nx[7:0];
	endtask

	// Work out what one accepted request does to the formatter.
	task automatic predict_char(input logic [7:0] c, input logic s);
		int row_y;
		if (s) begin
			shadow_escape = 1'b0;
			shadow_x      = '0;
			shadow_y      = '0;
			shadow_colour = COLOUR_WHITE;
		end
		if (c == CHAR_NUL) begin
			// End of text: drop any trailing slash, no placement.
			shadow_escape = 1'b0;
		end else if (shadow_escape) begin
			shadow_escape = 1'b0;
			if (c == CHAR_SLASH) begin
				place_glyph(c);
			end else if (c >= CHAR_ZERO && c <= CHAR_SIX) begin
				row_y = (GLYPH_HEIGHT + 1) * int'(c - CHAR_ZERO);
				shadow_x = '0;
				shadow_y = (row_y > 63) ? 6'd63 : row_y[5:0];
			end else begin
				// Unknown letters fall through and leave the colour alone.
				for (int i = 0; i < NUM_COLOURS; i++)
					if (letter_of(colour_t'(i)) == c)
						shadow_colour = i[3:0];
			end
		end else if (c == CHAR_SLASH) begin
			shadow_escape = 1'b1;
		end else begin
			place_glyph(c);
		end
	endtask

	// Present one request, hold it until accepted, then predict its effect.
	// Entered and left at a falling edge.
	task automatic send_char(input logic [7:0] c, input logic s = 1'b0);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid    <= 1'b1;
		char_code     <= c;
		start_of_text <= s;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		predict_char(c, s);
		bytes_sent++;
		if (s)
			strings_sent++;
		@(negedge clk);
	endtask

	task automatic send_escape(input logic [7:0] arg, input logic s = 1'b0);
		send_char(CHAR_SLASH, s);
		send_char(arg);
		escapes_sent++;
	endtask

	// Pick the second byte of an escape: mostly well-formed, some unknown.
	function automatic logic [7:0] pick_escape_arg();
		case ($urandom_range(0, 7))
			0:       return CHAR_SLASH;
			1, 2:    return CHAR_ZERO + 8'($urandom_range(0, 6));
			3, 4, 5: return letter_of(colour_t'($urandom_range(0, NUM_COLOURS - 1)));
			6:       return 8'($urandom_range(0, 255));
			default: return CHAR_NUL;
		endcase
	endfunction

	// Drive glyph_ready: stall a random number of cycles ahead of each result.
	initial begin : glyph_sink
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				glyph_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			glyph_ready <= 1'b1;
			@(posedge clk);
			while (!glyph_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%02h, got 0x%02h",
				$time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each delivered placement with the oldest one outstanding.
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && glyph_valid && glyph_ready) begin
			if (expected_glyphs.size() == 0) begin
				$display("%0t: unexpected placement: expected none, got code 0x%02h",
					$time, glyph_code);
				mismatches++;
			end else begin
				want = expected_glyphs.pop_front();
				check_field("glyph_code", want.code, glyph_code);
				check_field("colour_index", 8'(want.colour), 8'(colour_index));
				check_field("pos_x", want.x, pos_x);
				check_field("pos_y", 8'(want.y), 8'(pos_y));
				check_field("on_screen", 8'(want.fits), 8'(on_screen));
				glyphs_checked++;
			end
		end
	end

	// Abandon the run if neither channel moves for too long.
	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_valid && text_ready) || (glyph_valid && glyph_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL text_escape_cursor_formatter");
		$finish;
	end

	// Printable extremes: control bytes, DEL and the top half all print.
	task automatic test_print_extremes();
		send_char("A", 1'b1);
		send_char(8'hFF);
		send_char(8'h01);
		send_char(8'h80);
		send_char(8'h7F);
	endtask

	// Slash-slash, row moves, colour selection and an unknown escape.
	task automatic test_escape_codes();
		send_escape(CHAR_SLASH);
		send_escape(CHAR_SIX);
		send_char("x");
		send_escape(CHAR_ZERO + 8'd7);
		send_escape(letter_of(CLR_BLACK));
		send_char("B");
		send_escape(letter_of(CLR_GRAY));
		send_char("b");
		send_escape(CHAR_ZERO);
	endtask

	// Trailing slashes: dropped by a zero byte and by a fresh string.
	task automatic test_escape_drop();
		send_escape(CHAR_NUL);
		send_char("C");
		send_char(CHAR_SLASH);
		send_char("D", 1'b1);
		send_char(CHAR_NUL, 1'b1);
		send_char("E");
	endtask

	// Random strings, mostly well-formed text with escapes; a few long ones
	// push the cursor off screen and into saturation.
	task automatic test_random_text(input int n_items);
		int  target;
		int  len;
		bit  first;
		target = bytes_sent + n_items;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 7) == 0)
				no_idle = !no_idle;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60)
			                                  : $urandom_range(1, 16);
			for (int k = 0; k < len; k++) begin
				// Mostly start only on the first byte; occasionally mid-string.
				first = (k == 0) || ($urandom_range(0, 49) == 0);
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
						send_char(8'($urandom_range(32, 126)), first);
					11, 12, 13, 14, 15:
						send_escape(pick_escape_arg(), first);
					16:
						send_char(8'($urandom_range(0, 255)), first);
					17:
						send_char(CHAR_NUL, first);
					18:
						send_char(CHAR_SLASH, first);
					default:
						send_char(8'($urandom_range(128, 255)), first);
				endcase
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin : main
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_print_extremes();
		test_escape_codes();
		test_escape_drop();
		test_random_text(RANDOM_ITEMS);
		text_valid <= 1'b0;

		// Drain the placements still in flight, then let the pipe settle.
		while (expected_glyphs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_glyphs.size() != 0) begin
			$display("%0t: %0d placements never arrived", $time,
				expected_glyphs.size());
			mismatches++;
		end
		$display("Sent %0d text bytes over %0d strings, %0d of them escapes;",
			bytes_sent, strings_sent, escapes_sent);
		$display("checked %0d placements, %0d mismatches.", glyphs_checked, mismatches);
		if (mismatches == 0)
			$display("PASS text_escape_cursor_formatter");
		else
			$display("FAIL text_escape_cursor_formatter");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+sv
sv/tecf_pkg.sv
sv/tecf_decode.sv
sv/text_escape_cursor_formatter.sv
sv/tecf_checker.sv
bench/tb_text_escape_cursor_formatter.sv
